@@ src/assert_macros.svh @@
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, also checked through reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/brb_pkg.sv @@
package brb_pkg;

  localparam int OP_W   = 2;
  localparam int DATA_W = 8;
  localparam int CAP_W  = 11;
  localparam int KIND_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_WR_OK    = 3'd0,
    KIND_WR_REJ   = 3'd1,
    KIND_RD_BYTE  = 3'd2,
    KIND_RD_REJ   = 3'd3,
    KIND_RST_DONE = 3'd4
  } kind_t;

endpackage

@@ src/brb_ifs.sv @@
interface brb_in_if;
  logic                       valid;
  logic                       ready;
  logic [brb_pkg::OP_W-1:0]   op;
  logic [brb_pkg::DATA_W-1:0] data;
  logic                       first;
  logic [brb_pkg::CAP_W-1:0]  length;
  logic                       consume;

  modport source (output valid, op, data, first, length, consume, input ready);
  modport sink   (input valid, op, data, first, length, consume, output ready);
endinterface

interface brb_out_if;
  logic                       valid;
  logic                       ready;
  logic [brb_pkg::KIND_W-1:0] kind;
  logic [brb_pkg::DATA_W-1:0] read_data;
  logic                       last;
  logic [brb_pkg::CAP_W-1:0]  free_space;
  logic                       full_res;

  modport source (output valid, kind, read_data, last, free_space, full_res, input ready);
  modport sink   (input valid, kind, read_data, last, free_space, full_res, output ready);
endinterface

@@ src/brb_ram.sv @@
module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/byte_ring_buffer_peek.sv @@
// channel  | dir | payload                                   | notes
// in_ch    | in  | op, data, first, length, consume          | valid/ready
// out_ch   | out | kind, read_data, last, free_space, full_res | valid/ready, registered
// cfg      | in  | cfg_wdata (capacity)                      | write on cfg_we
//
// write, reset and rejected items are each done on acceptance, back to back while the output is not stalled
// a read of n bytes holds off the input until its last byte is loaded into the output: one byte memory read port,
// one byte per cycle while the output is not stalled, and a registered memory read
// output stalls pause the read sequencer without losing bytes
// synchronous reset clears pointers, counts and run state; the byte store is not cleared
module byte_ring_buffer_peek #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  brb_in_if.sink                    in_ch,
  brb_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [brb_pkg::CAP_W-1:0] cfg_wdata
);

  localparam int CAP_W = brb_pkg::CAP_W;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CMP_W = (PTR_W + 1 > CAP_W) ? PTR_W + 1 : CAP_W;
  localparam int RL_W  = $clog2(MAX_READ + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] c;
    if (v == '0) begin
      c = CAP_W'(1);
    end else if (CMP_W'(v) > CMP_W'(DEPTH)) begin
      c = CAP_W'(DEPTH);
    end else begin
      c = v;
    end
    return c;
  endfunction

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [CAP_W-1:0] cap);
    logic [CMP_W-1:0] n;
    logic [PTR_W-1:0] q;
    n = CMP_W'(p) + CMP_W'(1);
    if (n >= CMP_W'(cap) || n >= CMP_W'(DEPTH)) begin
      q = '0;
    end else begin
      q = PTR_W'(n);
    end
    return q;
  endfunction

  state_t                     state_r, state_nxt;
  logic [CAP_W-1:0]           cap_r, cap_nxt;
  logic [PTR_W-1:0]           wp_r, wp_nxt;
  logic [PTR_W-1:0]           rp_r, rp_nxt;
  logic [CAP_W-1:0]           stored_r, stored_nxt;
  logic [CAP_W-1:0]           rem_r, rem_nxt;
  logic                       adm_r, adm_nxt;
  logic [PTR_W-1:0]           rd_addr_r, rd_addr_nxt;
  logic [RL_W-1:0]            rd_left_r, rd_left_nxt;
  logic                       consume_r, consume_nxt;
  logic                       rd_pend_r, rd_pend_nxt;
  logic                       pend_last_r, pend_last_nxt;

  logic                       out_valid_r, out_valid_nxt;
  brb_pkg::kind_t             out_kind_r, out_kind_nxt;
  logic [brb_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [CAP_W-1:0]           out_free_r, out_free_nxt;
  logic                       out_full_r, out_full_nxt;

  logic                       ram_we, ram_re;
  logic [brb_pkg::DATA_W-1:0] ram_rdata;
  logic                       can_load, accept, pend_move, issue, res_load;
  logic [CAP_W-1:0]           free_now;
  brb_pkg::op_t               op;

  brb_ram #(.WIDTH(brb_pkg::DATA_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_ch.data),
    .re    (ram_re),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  assign can_load     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && can_load;
  assign accept       = in_ch.valid && in_ch.ready;
  assign op           = brb_pkg::op_t'(in_ch.op);
  assign pend_move    = rd_pend_r && can_load;
  assign free_now     = (stored_r >= cap_r) ? '0 : cap_r - stored_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.read_data  = out_data_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.free_space = out_free_r;
  assign out_ch.full_res   = out_full_r;

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cfg_we ? clamp_cap(cfg_wdata) : cap_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    stored_nxt    = stored_r;
    rem_nxt       = rem_r;
    adm_nxt       = adm_r;
    rd_addr_nxt   = rd_addr_r;
    rd_left_nxt   = rd_left_r;
    consume_nxt   = consume_r;
    rd_pend_nxt   = rd_pend_r;
    pend_last_nxt = pend_last_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    issue         = 1'b0;
    res_load      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = '0;
    out_last_nxt  = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            brb_pkg::OP_WRITE: begin
              if (in_ch.first) begin
                adm_nxt = 1'b0;
                rem_nxt = '0;
                if (in_ch.length == '0 || in_ch.length > free_now) begin
                  res_load     = 1'b1;
                  out_kind_nxt = brb_pkg::KIND_WR_REJ;
                end else begin
                  if (stored_r < cap_r) begin
                    ram_we     = 1'b1;
                    wp_nxt     = advance(wp_r, cap_r);
                    stored_nxt = stored_r + CAP_W'(1);
                  end
                  rem_nxt = in_ch.length - CAP_W'(1);
                  if (in_ch.length == CAP_W'(1)) begin
                    res_load     = 1'b1;
                    out_kind_nxt = brb_pkg::KIND_WR_OK;
                  end else begin
                    adm_nxt = 1'b1;
                  end
                end
              end else if (adm_r && rem_r != '0) begin
                if (stored_r < cap_r) begin
                  ram_we     = 1'b1;
                  wp_nxt     = advance(wp_r, cap_r);
                  stored_nxt = stored_r + CAP_W'(1);
                end
                rem_nxt = rem_r - CAP_W'(1);
                if (rem_r == CAP_W'(1)) begin
                  adm_nxt      = 1'b0;
                  res_load     = 1'b1;
                  out_kind_nxt = brb_pkg::KIND_WR_OK;
                end
              end
            end
            brb_pkg::OP_READ: begin
              if (in_ch.length == '0 || in_ch.length > CAP_W'(MAX_READ) ||
                  in_ch.length > stored_r) begin
                res_load     = 1'b1;
                out_kind_nxt = brb_pkg::KIND_RD_REJ;
              end else begin
                state_nxt   = ST_READ;
                rd_addr_nxt = rp_r;
                rd_left_nxt = RL_W'(in_ch.length);
                consume_nxt = in_ch.consume;
                if (in_ch.consume) begin
                  stored_nxt = stored_r - in_ch.length;
                end
              end
            end
            brb_pkg::OP_RESET: begin
              wp_nxt       = '0;
              rp_nxt       = '0;
              stored_nxt   = '0;
              rem_nxt      = '0;
              adm_nxt      = 1'b0;
              res_load     = 1'b1;
              out_kind_nxt = brb_pkg::KIND_RST_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        issue = (rd_left_r != '0) && (!rd_pend_r || can_load);
        if (issue) begin
          ram_re        = 1'b1;
          rd_addr_nxt   = advance(rd_addr_r, cap_r);
          rd_left_nxt   = rd_left_r - RL_W'(1);
          rd_pend_nxt   = 1'b1;
          pend_last_nxt = (rd_left_r == RL_W'(1));
          if (rd_left_r == RL_W'(1) && consume_r) begin
            rp_nxt = advance(rd_addr_r, cap_r);
          end
        end else if (pend_move) begin
          rd_pend_nxt = 1'b0;
        end
        if (pend_move) begin
          res_load     = 1'b1;
          out_kind_nxt = brb_pkg::KIND_RD_BYTE;
          out_data_nxt = ram_rdata;
          out_last_nxt = pend_last_r;
        end
        if (rd_left_r == '0 && (!rd_pend_r || pend_move)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_free_nxt = (stored_nxt >= cap_r) ? '0 : cap_r - stored_nxt;
    out_full_nxt = (stored_nxt >= cap_r);

    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= clamp_cap(brb_pkg::CAP_RESET);
      wp_r        <= '0;
      rp_r        <= '0;
      stored_r    <= '0;
      rem_r       <= '0;
      adm_r       <= 1'b0;
      rd_left_r   <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      stored_r    <= stored_nxt;
      rem_r       <= rem_nxt;
      adm_r       <= adm_nxt;
      rd_left_r   <= rd_left_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r   <= rd_addr_nxt;
    consume_r   <= consume_nxt;
    pend_last_r <= pend_last_nxt;
    if (res_load) begin
      out_kind_r <= out_kind_nxt;
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
      out_free_r <= out_free_nxt;
      out_full_r <= out_full_nxt;
    end
  end

endmodule

@@ src/brb_checker.sv @@
`include "assert_macros.svh"

module brb_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [brb_pkg::KIND_W-1:0] out_kind,
  input logic [brb_pkg::DATA_W-1:0] out_read_data,
  input logic                       out_last,
  input logic [brb_pkg::CAP_W-1:0]  out_free_space,
  input logic                       out_full_res
);

  logic single_res;

  assign single_res = out_valid && out_kind != brb_pkg::KIND_RD_BYTE;

  // a stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // single results are always marked last and carry no byte
  `ASSERT_SAME(a_single_last, clk, rst_n, single_res, out_last && out_read_data == '0)

  // fullness and free space agree
  `ASSERT_SAME(a_full_free, clk, rst_n, out_valid, out_full_res == (out_free_space == '0))

  // nothing is offered right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid)

endmodule

bind byte_ring_buffer_peek brb_checker u_brb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_read_data  (out_ch.read_data),
  .out_last       (out_ch.last),
  .out_free_space (out_ch.free_space),
  .out_full_res   (out_ch.full_res)
);
